/* sv/hid_keyboard_report_builder_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard report builder
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_BUILDER_CORE_DEFINES_SVH
`define HID_KEYBOARD_REPORT_BUILDER_CORE_DEFINES_SVH

// Checked on every rising clock edge, switched off while reset is asserted.
`define HKRB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, but the property also holds during reset.
`define HKRB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/hkrb_pkg.sv */
// ----------------------------------------------------------------------------
// hkrb_pkg
// Types, constants and the ASCII keycode table of the keyboard report builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hkrb_pkg;

  localparam int KeySlots   = 5;  // key slots kept in the report, 1 to 6
  localparam int ShownSlots = 5;  // key slots carried on the output
  localparam int KeyW       = 7;
  localparam int CodeW      = 8;
  localparam int ModW       = 8;

  localparam logic [CodeW-1:0] RawBase   = 8'd136;
  localparam logic [ModW-1:0]  ShiftMask = 8'h02;

  typedef enum logic [1:0] {
    OP_PRESS       = 2'd0,
    OP_RELEASE     = 2'd1,
    OP_TYPE        = 2'd2,
    OP_RELEASE_ALL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRESS,
    ST_RELEASE,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic capture;     // latch the incoming key code
    logic do_press;
    logic do_release;
    logic do_clear;
    logic load_out;    // copy the updated report into the output register
    logic last;
  } cmd_t;

  typedef struct packed {
    logic press_emit;  // a press would send a report
    logic rel_emit;    // a release would send a report
  } status_t;

  // Bit 7 adds left shift, bits 6..0 are the keycode, zero means unmapped.
  localparam logic [7:0] AsciiRom [0:127] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2a, 8'h2b, 8'h28, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h2c, 8'h9e, 8'hb4, 8'ha0,
    8'ha1, 8'ha2, 8'ha4, 8'h34, 8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
    8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'hb3, 8'h33,
    8'hb6, 8'h2e, 8'hb7, 8'hb8, 8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
    8'h97, 8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
    8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e,
    8'h0f, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
    8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
  };

endpackage

/* sv/hkrb_datapath.sv */
// ----------------------------------------------------------------------------
// hkrb_datapath
// Key code decode, report state (modifier byte and key slots) and the
// output report register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hkrb_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hkrb_pkg::cmd_t                      cmd_i,
  input  logic [hkrb_pkg::CodeW-1:0]          key_code_i,
  output hkrb_pkg::status_t                   status_o,
  output logic [hkrb_pkg::ModW-1:0]           out_mod_o,
  output logic [hkrb_pkg::ShownSlots-1:0][hkrb_pkg::KeyW-1:0] out_slots_o,
  output logic                                out_last_o
);

  logic [hkrb_pkg::CodeW-1:0] code_q;
  logic [hkrb_pkg::ModW-1:0]  mod_q, mod_d;
  logic [hkrb_pkg::KeyW-1:0]  slots_q [hkrb_pkg::KeySlots];
  logic [hkrb_pkg::KeyW-1:0]  slots_d [hkrb_pkg::KeySlots];

  logic [hkrb_pkg::ModW-1:0]  out_mod_q;
  logic [hkrb_pkg::ShownSlots-1:0][hkrb_pkg::KeyW-1:0] out_slots_q, out_slots_d;
  logic                       out_last_q;

  logic [7:0]                 rom_word;
  logic                       mapped;
  logic [hkrb_pkg::KeyW-1:0]  kc;
  logic [hkrb_pkg::ModW-1:0]  mm;
  logic                       present;
  logic                       has_free;
  logic                       placed;

  // Decode the latched code into keycode, modifier mask and a mapped flag.
  always_comb begin
    rom_word = hkrb_pkg::AsciiRom[code_q[6:0]];
    mapped   = 1'b1;
    kc       = '0;
    mm       = '0;
    if (code_q >= hkrb_pkg::RawBase) begin
      kc = hkrb_pkg::KeyW'(code_q - hkrb_pkg::RawBase);
    end else if (code_q[7]) begin
      mm = hkrb_pkg::ModW'(1) << code_q[2:0];
    end else begin
      mapped = (rom_word != 8'h00);
      if (rom_word[7]) begin
        mm = hkrb_pkg::ShiftMask;
      end
      kc = rom_word[6:0];
    end
  end

  always_comb begin
    present  = 1'b0;
    has_free = 1'b0;
    for (int i = 0; i < hkrb_pkg::KeySlots; i++) begin
      if (slots_q[i] == kc) present = 1'b1;
      if (slots_q[i] == '0) has_free = 1'b1;
    end
  end

  assign status_o.press_emit = mapped && ((kc == '0) || present || has_free);
  assign status_o.rel_emit   = mapped;

  always_comb begin
    mod_d   = mod_q;
    slots_d = slots_q;
    placed  = 1'b0;
    if (cmd_i.do_clear) begin
      mod_d = '0;
      for (int i = 0; i < hkrb_pkg::KeySlots; i++) slots_d[i] = '0;
    end else if (cmd_i.do_press && mapped) begin
      mod_d = mod_q | mm;
      // A new key goes into the first empty slot, unless it is already held.
      if ((kc != '0) && !present) begin
        for (int i = 0; i < hkrb_pkg::KeySlots; i++) begin
          if (!placed && (slots_q[i] == '0)) begin
            slots_d[i] = kc;
            placed     = 1'b1;
          end
        end
      end
    end else if (cmd_i.do_release && mapped) begin
      mod_d = mod_q & ~mm;
      if (kc != '0) begin
        for (int i = 0; i < hkrb_pkg::KeySlots; i++) begin
          if (slots_q[i] == kc) slots_d[i] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < hkrb_pkg::ShownSlots; s++) begin
      out_slots_d[s] = '0;
      if (s < hkrb_pkg::KeySlots) out_slots_d[s] = slots_d[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= '0;
      for (int i = 0; i < hkrb_pkg::KeySlots; i++) slots_q[i] <= '0;
    end else begin
      mod_q   <= mod_d;
      slots_q <= slots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      code_q <= key_code_i;
    end
    if (cmd_i.load_out) begin
      out_mod_q   <= mod_d;
      out_slots_q <= out_slots_d;
      out_last_q  <= cmd_i.last;
    end
  end

  assign out_mod_o   = out_mod_q;
  assign out_slots_o = out_slots_q;
  assign out_last_o  = out_last_q;

endmodule

/* sv/hkrb_ctrl.sv */
// ----------------------------------------------------------------------------
// hkrb_ctrl
// Sequencer for key events and the valid flag of the output report register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hid_keyboard_report_builder_core_defines.svh"

module hkrb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  hkrb_pkg::status_t status_i,
  output hkrb_pkg::cmd_t    cmd_o
);

  hkrb_pkg::state_e state_q, state_d;
  logic             type_q, type_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             accept;
  logic             emit;
  logic             advance;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    type_d     = type_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    advance    = 1'b0;
    case (state_q)
      hkrb_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          type_d = (hkrb_pkg::op_e'(in_op_i) == hkrb_pkg::OP_TYPE);
          case (hkrb_pkg::op_e'(in_op_i))
            hkrb_pkg::OP_PRESS, hkrb_pkg::OP_TYPE: state_d = hkrb_pkg::ST_PRESS;
            hkrb_pkg::OP_RELEASE:                  state_d = hkrb_pkg::ST_RELEASE;
            default:                               state_d = hkrb_pkg::ST_CLEAR;
          endcase
        end
      end
      hkrb_pkg::ST_PRESS: begin
        emit           = status_i.press_emit;
        advance        = !emit || out_free;
        cmd_o.do_press = advance;
        cmd_o.last     = !type_q;
        if (advance) begin
          state_d = type_q ? hkrb_pkg::ST_RELEASE : hkrb_pkg::ST_IDLE;
        end
      end
      hkrb_pkg::ST_RELEASE: begin
        emit             = status_i.rel_emit;
        advance          = !emit || out_free;
        cmd_o.do_release = advance;
        cmd_o.last       = 1'b1;
        if (advance) state_d = hkrb_pkg::ST_IDLE;
      end
      hkrb_pkg::ST_CLEAR: begin
        emit           = 1'b1;
        advance        = out_free;
        cmd_o.do_clear = advance;
        cmd_o.last     = 1'b1;
        if (advance) state_d = hkrb_pkg::ST_IDLE;
      end
      default: begin
        state_d = hkrb_pkg::ST_IDLE;
      end
    endcase
    cmd_o.load_out = emit && advance;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hkrb_pkg::ST_IDLE;
      type_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      type_q      <= type_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `HKRB_ASSERT(a_accept_leaves_idle, accept |=> state_q != hkrb_pkg::ST_IDLE, "accepted request did not start work")
  `HKRB_ASSERT(a_no_overwrite, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "report register overwritten before it was taken")
  `HKRB_ASSERT(a_type_releases, (state_q == hkrb_pkg::ST_PRESS && type_q && advance) |=> state_q == hkrb_pkg::ST_RELEASE, "type request skipped its release")
  `HKRB_ASSERT(a_single_update, $countones({cmd_o.do_press, cmd_o.do_release, cmd_o.do_clear}) <= 1, "more than one report update in a cycle")

endmodule

/* sv/hid_keyboard_report_builder_core.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_core
// Keeps a keyboard report (modifier byte and key slots) and sends copies on key events.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one key event per request: tuser carries the
//   operation (press, release, type, release all) and tdata the key code.
//   The master stream sends one report per request: modifier byte and five
//   key slots in tdata, with tlast set on the final report of the event.
//   An event sends zero, one or two reports (type sends press then release).
//   An event's code is captured when it is accepted in idle; each report
//   step in the sequencer then updates the report state and loads any
//   report into the output register. The sequencer handles one event at a
//   time. The next event is taken as soon as the sequencer is back in idle,
//   even while the last report still waits in the output register.
//   Reset clears the modifier byte and all key slots and drops any pending
//   report. When the receiver stalls, a step that must send a report waits
//   until the output register is free; the report state is not updated early.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_keyboard_report_builder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] key_code
  input  logic [1:0]  s_axis_tuser,  // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] modifier_bits, [14:8] slot_zero, [21:15] slot_one, [28:22] slot_two,
  // [35:29] slot_three, [42:36] slot_four, [47:43] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast   // last_report
);

  hkrb_pkg::cmd_t    cmd;
  hkrb_pkg::status_t status;
  logic [hkrb_pkg::ModW-1:0] out_mod;
  logic [hkrb_pkg::ShownSlots-1:0][hkrb_pkg::KeyW-1:0] out_slots;

  hkrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hkrb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .key_code_i  (s_axis_tdata),
    .status_o    (status),
    .out_mod_o   (out_mod),
    .out_slots_o (out_slots),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, out_slots, out_mod};

endmodule
